@@ rtl/core/sgm_pkg.sv @@
// Shared constants, payload and control types for the Sobel gradient magnitude unit.
package sgm_pkg;

    // Frame limits
    localparam int W_MAX = 1024;
    localparam int H_MAX = 4096;

    // Field and counter widths
    localparam int PIX_W  = 8;
    localparam int WID_W  = 11;                // image_width register
    localparam int HGT_W  = 13;                // image_height register
    localparam int COL_W  = $clog2(W_MAX);     // column counters, line memory address
    localparam int ROW_W  = HGT_W;             // input row, runs up to a couple past the height
    localparam int OROW_W = $clog2(H_MAX);     // output row

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

    // Item kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Gradient and root arithmetic
    localparam int ABS_W  = PIX_W + 2;         // |Gx|, |Gy| up to 4*255
    localparam int SQR_W  = 2 * ABS_W;         // one square
    localparam int SQ_W   = SQR_W + 1;         // sum of both squares
    localparam int ROOT_W = PIX_W;             // saturated result
    localparam int HALF_W = 2 * ROOT_W;        // radicand bits below saturation
    localparam int REM_W  = ROOT_W + 3;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int CNT_W  = $clog2(ROOT_STEPS);
    localparam logic [ROOT_W-1:0] MAG_MAX = 8'd255;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel;
    } pix_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic             last_of_frame;
    } mag_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
    } line_entry_t;

    // Controller to datapath
    typedef struct packed {
        logic cfg_write;
        logic take_item;
        logic restart;
        logic rd_issue;
        logic advance;
        logic grad;
        logic square;
        logic root_start;
        logic out_load;
    } sgm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_flush;
        logic frame_done;
        logic row_ge_h;
        logic emit;
        logic root_busy;
        logic out_free;
        logic out_last;
    } sgm_sts_t;

endpackage

@@ rtl/core/sgm_ctrl.sv @@
// Sequencing state machine of the Sobel gradient magnitude unit.
module sgm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  sgm_pkg::sgm_sts_t sts,
    output sgm_pkg::sgm_cmd_t cmd
);
    import sgm_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_ISSUE = 4'd2;
    localparam logic [3:0] ST_ADV   = 4'd3;
    localparam logic [3:0] ST_GRAD  = 4'd4;
    localparam logic [3:0] ST_SQR   = 4'd5;
    localparam logic [3:0] ST_START = 4'd6;
    localparam logic [3:0] ST_ROOT  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        pix_stall  = 1'b1;
        cfg_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pix_stall     = 1'b0;
                cfg_ready     = 1'b1;
                cmd.cfg_write = cfg_valid;
                if (pix_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // a pixel after a finished frame starts a new one, then is checked again
                priority if (!sts.is_flush && sts.frame_done)
                    cmd.restart = 1'b1;
                else if (!sts.is_flush && sts.row_ge_h)
                    state_next = ST_IDLE;
                else if (sts.is_flush && (sts.frame_done || !sts.row_ge_h))
                    state_next = ST_IDLE;
                else
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_ADV;
            end
            ST_ADV:
            begin
                cmd.advance = 1'b1;
                priority if (sts.emit)
                    state_next = ST_GRAD;
                else if (sts.is_flush)
                    state_next = ST_ISSUE;
                else
                    state_next = ST_IDLE;
            end
            ST_GRAD:
            begin
                cmd.grad   = 1'b1;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                cmd.square = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (!sts.root_busy)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/core/sgm_isqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle, saturated.
module sgm_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sgm_pkg::SQ_W-1:0]   value,
    output logic                       busy,
    output logic [sgm_pkg::ROOT_W-1:0] root
);
    import sgm_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [HALF_W-1:0] val_reg;
    logic [HALF_W-1:0] val_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic              sat_reg;
    logic              sat_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        sat_next  = sat_reg;
        rem_sh    = {rem_reg[REM_W-3:0], val_reg[HALF_W-1:HALF_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = value[HALF_W-1:0];
            rem_next  = '0;
            root_next = '0;
            sat_next  = |value[SQ_W-1:HALF_W];
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[HALF_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        sat_reg  <= sat_next;
    end

    assign busy = busy_reg;
    assign root = sat_reg ? MAG_MAX : root_reg;

endmodule

@@ rtl/core/sgm_datapath.sv @@
// Line memory, 3x3 window, counters, gradient, squares and output register.
module sgm_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sgm_pkg::sgm_cmd_t              cmd,
    output sgm_pkg::sgm_sts_t              sts,
    input  sgm_pkg::pix_item_t             pix_item,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           mag_stall,
    output logic                           mag_valid,
    output sgm_pkg::mag_item_t             mag_item
);
    import sgm_pkg::*;

    function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] v);
        logic [WID_W-1:0] r;
        if (v == '0)
            r = WID_W'(1);
        else if (v > WID_W'(W_MAX))
            r = WID_W'(W_MAX);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [HGT_W-1:0] clamp_height(input logic [HGT_W-1:0] v);
        logic [HGT_W-1:0] r;
        if (v == '0)
            r = HGT_W'(1);
        else if (v > HGT_W'(H_MAX))
            r = HGT_W'(H_MAX);
        else
            r = v;
        return r;
    endfunction

    // Configuration, stored already clamped
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic             cfg_hit;
    logic             restart_any;

    pix_item_t item_reg;
    logic      is_pixel;

    // Frame counters
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [COL_W-1:0]  ocol_reg, ocol_next;
    logic [OROW_W-1:0] orow_reg, orow_next;
    logic              done_reg, done_next;
    logic              col_last;
    logic              ocol_last;
    logic              out_last;

    // Line memory: two previous rows side by side
    line_entry_t line_mem [W_MAX];
    line_entry_t rd_reg;

    // Window and gradient
    logic [8:0][PIX_W-1:0] win_reg, win_next;
    logic [8:0][PIX_W-1:0] win_adv;
    logic [8:0][PIX_W-1:0] loc;
    logic [8:0][PIX_W-1:0] sw_reg;
    logic [2:0][PIX_W-1:0] col_px;
    logic                  emit;
    logic [ABS_W-1:0]      gx_pos, gx_neg, gy_pos, gy_neg;
    logic [ABS_W-1:0]      gx_abs_reg, gy_abs_reg;
    logic [SQR_W-1:0]      sqx_reg, sqy_reg;
    logic [SQ_W-1:0]       sq_sum;
    logic                  root_busy;
    logic [ROOT_W-1:0]     root;

    // Output register
    logic      out_valid_reg, out_valid_next;
    mag_item_t out_item_reg;
    logic      out_free;

    assign cfg_hit     = cmd.cfg_write
                         && (cfg_index == CFG_IDX_WIDTH || cfg_index == CFG_IDX_HEIGHT);
    assign restart_any = cmd.restart || cfg_hit;
    assign is_pixel    = (item_reg.action == ACT_PIXEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cmd.cfg_write)
        begin
            if (cfg_index == CFG_IDX_WIDTH)
                width_reg <= clamp_width(cfg_data[WID_W-1:0]);
            if (cfg_index == CFG_IDX_HEIGHT)
                height_reg <= clamp_height(cfg_data[HGT_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
            item_reg <= pix_item;
    end

    // Window step: replicate the left edge at column zero, else shift in a column
    always_comb
    begin
        col_px[0] = (row_reg == ROW_W'(1)) ? rd_reg.middle : rd_reg.upper;
        col_px[1] = rd_reg.middle;
        col_px[2] = is_pixel ? item_reg.pixel : rd_reg.middle;
        for (int r = 0; r < 3; r++)
        begin
            if (col_reg == '0)
            begin
                win_adv[r*3+0] = col_px[r];
                win_adv[r*3+1] = col_px[r];
                win_adv[r*3+2] = col_px[r];
            end
            else
            begin
                win_adv[r*3+0] = win_reg[r*3+1];
                win_adv[r*3+1] = win_reg[r*3+2];
                win_adv[r*3+2] = col_px[r];
            end
            // right edge of the previous row, last column repeated
            loc[r*3+0] = win_reg[r*3+1];
            loc[r*3+1] = win_reg[r*3+2];
            loc[r*3+2] = win_reg[r*3+2];
        end
        emit = (col_reg == '0) ? (row_reg >= ROW_W'(2)) : (row_reg >= ROW_W'(1));
    end

    assign col_last  = (WID_W'(col_reg) + WID_W'(1)) >= width_reg;
    assign ocol_last = (WID_W'(ocol_reg) + WID_W'(1)) >= width_reg;
    assign out_last  = ocol_last && ((HGT_W'(orow_reg) + HGT_W'(1)) >= height_reg);
    assign out_free  = !out_valid_reg || !mag_stall;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        done_next = done_reg;
        win_next  = win_reg;
        priority if (restart_any)
        begin
            col_next  = '0;
            row_next  = '0;
            ocol_next = '0;
            orow_next = '0;
            done_next = 1'b0;
            win_next  = '0;
        end
        else if (cmd.advance)
        begin
            win_next = win_adv;
            if (col_last)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        else if (cmd.out_load)
        begin
            priority if (out_last)
                done_next = 1'b1;
            else if (ocol_last)
            begin
                ocol_next = '0;
                orow_next = orow_reg + OROW_W'(1);
            end
            else
                ocol_next = ocol_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            done_reg <= 1'b0;
            win_reg  <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            done_reg <= done_next;
            win_reg  <= win_next;
        end
    end

    // Line memory: read into a register in the state before the window step, write back during the window step
    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
            rd_reg <= line_mem[col_reg];
        if (cmd.advance && is_pixel)
            line_mem[col_reg] <= '{upper: rd_reg.middle, middle: item_reg.pixel};
    end

    assign gx_pos = ABS_W'(sw_reg[2]) + ABS_W'({sw_reg[5], 1'b0}) + ABS_W'(sw_reg[8]);
    assign gx_neg = ABS_W'(sw_reg[0]) + ABS_W'({sw_reg[3], 1'b0}) + ABS_W'(sw_reg[6]);
    assign gy_pos = ABS_W'(sw_reg[6]) + ABS_W'({sw_reg[7], 1'b0}) + ABS_W'(sw_reg[8]);
    assign gy_neg = ABS_W'(sw_reg[0]) + ABS_W'({sw_reg[1], 1'b0}) + ABS_W'(sw_reg[2]);
    assign sq_sum = SQ_W'(sqx_reg) + SQ_W'(sqy_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.advance)
            sw_reg <= (col_reg == '0) ? loc : win_adv;
        if (cmd.grad)
        begin
            gx_abs_reg <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
            gy_abs_reg <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        end
        if (cmd.square)
        begin
            sqx_reg <= gx_abs_reg * gx_abs_reg;
            sqy_reg <= gy_abs_reg * gy_abs_reg;
        end
    end

    sgm_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.root_start),
        .value (sq_sum),
        .busy  (root_busy),
        .root  (root)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!mag_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_item_reg <= '{magnitude: root, last_of_frame: out_last};
    end

    assign mag_valid = out_valid_reg;
    assign mag_item  = out_item_reg;

    assign sts.is_flush   = (item_reg.action == ACT_FLUSH);
    assign sts.frame_done = done_reg;
    assign sts.row_ge_h   = (row_reg >= height_reg);
    assign sts.emit       = emit;
    assign sts.root_busy  = root_busy;
    assign sts.out_free   = out_free;
    assign sts.out_last   = out_last;

endmodule

@@ rtl/core/sobel_gradient_magnitude_unit.sv @@
// One item at a time: a pixel after a finished frame restarts it, an ignored item ends
// at the check, and one that yields a result passes the gradient, squares and 8-step
// root unit into the output register before the next is taken. A flush may step over
// an empty slot. Results trail the pixels by width+1 items.
// Reset (asynchronous, active low) clears counters, window, output valid and sets
// the size registers to 640 x 480; the line memory keeps whatever it holds.
module sobel_gradient_magnitude_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // pixel and flush items
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  sgm_pkg::pix_item_t             pix_item,
    // gradient magnitudes
    output logic                           mag_valid,
    input  logic                           mag_stall,
    output sgm_pkg::mag_item_t             mag_item,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sgm_pkg::*;

    sgm_cmd_t cmd;
    sgm_sts_t sts;

    // The controller takes one item at a time: it checks the item against the frame
    // state, reads the two stored rows at the input column, steps the window,
    // then walks the gradient, squares and root before loading the output register.
    // The output register holds its result while the next item is already taken.
    sgm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath owns every piece of frame state and the single-port line memory.
    // A register write with a known index restarts the frame; the rows stay put.
    sgm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .pix_item  (pix_item),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mag_stall (mag_stall),
        .mag_valid (mag_valid),
        .mag_item  (mag_item)
    );

    // Never overwrite a result that is still waiting for its transfer.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(mag_valid && mag_stall))
        else $error("output register loaded while a result was held");

    // The root unit is started only when it has finished the previous radicand.
    a_root_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root_start |-> !sts.root_busy)
        else $error("root unit restarted while busy");

    // The bottom right result closes the frame.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && sts.out_last |=> sts.frame_done)
        else $error("frame not closed after its last result");

    // Once the frame is closed, nothing advances the window until a restart.
    a_no_step_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        sts.frame_done |-> !cmd.advance)
        else $error("window advanced on a finished frame");

endmodule
